>>> rtl/ucv_pkg.sv
// Shared types, constants and status codes of the UDP checksum checker.
package ucv_pkg;

    localparam logic [7:0]  PROTO_UDP = 8'h11;
    localparam logic [15:0] COUNT_MAX = 16'hFFFF;

    localparam logic [1:0] ST_GOOD      = 2'd0;
    localparam logic [1:0] ST_NOT_UDP   = 2'd1;
    localparam logic [1:0] ST_BAD       = 2'd2;
    localparam logic [1:0] ST_TRUNCATED = 2'd3;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } t_in;

    typedef struct packed {
        logic [15:0] byte_count;
        logic [5:0]  header_bytes;
        logic [7:0]  protocol_seen;
        logic [15:0] segment_length;
        logic [15:0] running_sum;
        logic        check_nonzero;
    } t_snap;

endpackage

>>> rtl/ucv_if.sv
// Valid/ready channel interfaces for packet bytes and check status.
interface ucv_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface ucv_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] status;

    modport source (output valid, output status, input ready);
    modport sink   (input valid, input status, output ready);
endinterface

>>> rtl/ucv_state.sv
// Per-byte header parsing and ones' complement accumulation, with packet snapshot.
module ucv_state (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  ucv_pkg::t_in    i_data,
    output logic            o_snap_valid,
    input  logic            i_snap_ready,
    output ucv_pkg::t_snap  o_snap
);

    logic [15:0] r_count;
    logic [5:0]  r_hdr;
    logic [7:0]  r_proto;
    logic [15:0] r_seglen;
    logic [15:0] r_sum;
    logic [7:0]  r_hold;
    logic        r_cnz;
    logic        r_snap_valid;
    ucv_pkg::t_snap r_snap;

    logic        a_fire;
    logic        upd;
    logic [7:0]  b;
    logic [5:0]  h_now;
    logic        ge_h;
    logic [15:0] ph;
    logic [15:0] v;
    logic        pseudo;
    logic        in_seg;
    logic [17:0] add_sum;
    logic [17:0] s1;
    logic [16:0] fold1;
    logic [16:0] fold2;
    ucv_pkg::t_snap n_state;
    logic [7:0]  n_hold;

    assign b       = i_data.data_byte;
    assign o_ready = !i_data.last_byte || !r_snap_valid || i_snap_ready;
    assign a_fire  = i_valid && o_ready;
    assign upd     = (r_count != ucv_pkg::COUNT_MAX);

    always_comb begin
        h_now   = (r_count == 16'd0) ? {b[3:0], 2'b00} : r_hdr;
        ge_h    = (r_count >= {10'd0, h_now});
        ph      = r_count - {10'd0, h_now};
        v       = r_count[0] ? {8'd0, b} : {b, 8'd0};
        pseudo  = (r_count >= 16'd12) && (r_count <= 16'd19);
        in_seg  = ge_h && ((ph < 16'd6) || (ph < r_seglen));
        add_sum = (pseudo ? {2'd0, v} : 18'd0)
                + (in_seg ? {2'd0, v} : 18'd0)
                + ((ge_h && ph == 16'd5) ? {2'd0, r_hold, b} : 18'd0);
        s1      = {2'd0, r_sum} + add_sum;
        fold1   = {1'b0, s1[15:0]} + {15'd0, s1[17:16]};
        fold2   = {1'b0, fold1[15:0]} + {16'd0, fold1[16]};

        n_state.byte_count     = r_count;
        n_state.header_bytes   = r_hdr;
        n_state.protocol_seen  = r_proto;
        n_state.segment_length = r_seglen;
        n_state.running_sum    = r_sum;
        n_state.check_nonzero  = r_cnz;
        n_hold                 = r_hold;
        if (upd) begin
            n_state.byte_count   = r_count + 16'd1;
            n_state.header_bytes = h_now;
            n_state.running_sum  = fold2[15:0];
            if (r_count == 16'd9) begin
                n_state.protocol_seen = b;
            end
            if (ge_h && ph == 16'd4) begin
                n_hold = b;
            end
            if (ge_h && ph == 16'd5) begin
                n_state.segment_length = {r_hold, b};
            end
            if (ge_h && (ph == 16'd6 || ph == 16'd7) && b != 8'd0) begin
                n_state.check_nonzero = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count      <= '0;
            r_hdr        <= '0;
            r_proto      <= '0;
            r_seglen     <= '0;
            r_sum        <= '0;
            r_hold       <= '0;
            r_cnz        <= 1'b0;
            r_snap_valid <= 1'b0;
        end else begin
            if (a_fire && i_data.last_byte) begin
                r_snap_valid <= 1'b1;
            end else if (i_snap_ready) begin
                r_snap_valid <= 1'b0;
            end
            if (a_fire) begin
                if (i_data.last_byte) begin
                    r_count      <= '0;
                    r_hdr        <= '0;
                    r_proto      <= '0;
                    r_seglen     <= '0;
                    r_sum        <= '0;
                    r_hold       <= '0;
                    r_cnz        <= 1'b0;
                end else begin
                    r_count  <= n_state.byte_count;
                    r_hdr    <= n_state.header_bytes;
                    r_proto  <= n_state.protocol_seen;
                    r_seglen <= n_state.segment_length;
                    r_sum    <= n_state.running_sum;
                    r_hold   <= n_hold;
                    r_cnz    <= n_state.check_nonzero;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (a_fire && i_data.last_byte) begin
            r_snap <= n_state;
        end
    end

    assign o_snap_valid = r_snap_valid;
    assign o_snap       = r_snap;

    a_last_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        a_fire && i_data.last_byte |=> r_count == 16'd0 && r_sum == 16'd0 && !r_cnz)
        else $error("state not cleared after final byte");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        a_fire && !i_data.last_byte && upd |=> r_count == $past(r_count) + 16'd1)
        else $error("byte count did not advance");

    a_sum_folded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        a_fire && upd |-> fold2[16] == 1'b0)
        else $error("running sum fold overflow");

    a_snap_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_snap_valid && !i_snap_ready |=> r_snap_valid && $stable(r_snap))
        else $error("snapshot lost while stalled");

endmodule

>>> rtl/ucv_decide.sv
// Status decision from a finished packet snapshot into the result register.
module ucv_decide (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_snap_valid,
    output logic            o_snap_ready,
    input  ucv_pkg::t_snap  i_snap,
    output logic            o_valid,
    input  logic            i_ready,
    output logic [1:0]      o_status
);

    logic        r_valid;
    logic [1:0]  r_status;
    logic [1:0]  n_status;
    logic [16:0] hdr_plus6;
    logic [16:0] need_sum;
    logic [16:0] need;
    logic [16:0] fin1;
    logic [16:0] fin2;
    logic        s_fire;

    assign o_snap_ready = !r_valid || i_ready;
    assign s_fire       = i_snap_valid && o_snap_ready;

    always_comb begin
        hdr_plus6 = {11'd0, i_snap.header_bytes} + 17'd6;
        need_sum  = {11'd0, i_snap.header_bytes} + {1'b0, i_snap.segment_length};
        need      = (need_sum < 17'd20) ? 17'd20 : need_sum;
        fin1      = {1'b0, i_snap.running_sum} + {9'd0, ucv_pkg::PROTO_UDP};
        fin2      = {1'b0, fin1[15:0]} + {16'd0, fin1[16]};
        priority if (i_snap.byte_count < 16'd10) begin
            n_status = ucv_pkg::ST_TRUNCATED;
        end else if (i_snap.protocol_seen != ucv_pkg::PROTO_UDP) begin
            n_status = ucv_pkg::ST_NOT_UDP;
        end else if ({1'b0, i_snap.byte_count} < hdr_plus6) begin
            n_status = ucv_pkg::ST_TRUNCATED;
        end else if (i_snap.segment_length < 16'd8) begin
            n_status = ucv_pkg::ST_BAD;
        end else if ({1'b0, i_snap.byte_count} < need) begin
            n_status = ucv_pkg::ST_TRUNCATED;
        end else if (!i_snap.check_nonzero) begin
            n_status = ucv_pkg::ST_GOOD;
        end else if (fin2[15:0] == 16'hFFFF) begin
            n_status = ucv_pkg::ST_GOOD;
        end else begin
            n_status = ucv_pkg::ST_BAD;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (s_fire) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_fire) begin
            r_status <= n_status;
        end
    end

    assign o_valid  = r_valid;
    assign o_status = r_status;

    a_fire_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_fire |=> r_valid && r_status == $past(n_status))
        else $error("result register not loaded");

    a_short_trunc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_fire && i_snap.byte_count < 16'd10 |=> r_status == ucv_pkg::ST_TRUNCATED)
        else $error("short packet not reported truncated");

endmodule

>>> rtl/udp_checksum_verify_core.sv
// Top level of the UDP checksum checker: input register, state stage, decision stage.
//
// Usage: IPv4 packet bytes enter on i_in (valid/ready), header first with the
// Ethernet header already removed; last_byte marks the final byte of a packet.
// One status transaction leaves on o_out for each packet, none for other bytes:
// 0 checksum good, 1 not UDP, 2 checksum bad, 3 truncated.
// Throughput: one byte per clock cycle while i_in.ready stays high, packets back to back with no gap.
// The status of a packet passes from the transaction carrying its final byte
// through the input register, the snapshot register and the status register
// in turn; a stall of the snapshot or the receiver can hold it between them.
// The per-byte accumulation is a single end-around-carry add with two folds.
// Reset (i_rst_n low, synchronous) empties all stages and clears packet state.
// When the receiver stalls, the status is held; bytes of the next packet keep
// flowing, and a further final byte waits in a snapshot register; only a third
// pending final byte stops i_in.ready.
module udp_checksum_verify_core (
    input  logic         i_clk,
    input  logic         i_rst_n,
    ucv_in_if.sink       i_in,
    ucv_out_if.source    o_out
);

    logic           r_a_valid;
    ucv_pkg::t_in   r_a;
    logic           st_ready;
    logic           snap_valid;
    logic           snap_ready;
    ucv_pkg::t_snap snap;
    logic           in_fire;

    assign i_in.ready = !r_a_valid || st_ready;
    assign in_fire    = i_in.valid && i_in.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (in_fire) begin
            r_a_valid <= 1'b1;
        end else if (st_ready) begin
            r_a_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_a.data_byte <= i_in.data_byte;
            r_a.last_byte <= i_in.last_byte;
        end
    end

    ucv_state u_state (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (r_a_valid),
        .o_ready      (st_ready),
        .i_data       (r_a),
        .o_snap_valid (snap_valid),
        .i_snap_ready (snap_ready),
        .o_snap       (snap)
    );

    ucv_decide u_decide (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_snap_valid (snap_valid),
        .o_snap_ready (snap_ready),
        .i_snap       (snap),
        .o_valid      (o_out.valid),
        .i_ready      (o_out.ready),
        .o_status     (o_out.status)
    );

endmodule

>>> sim/tb.sv
// Self-checking testbench of the UDP checksum checker: packet stimulus, status prediction.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int RANDOM_BYTES = 1850;
    localparam int MIN_PACKETS  = 48;
    localparam int HOLD_AT      = 30;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_LIMIT  = 5000;
    localparam int SETTLE       = 8;

    typedef logic [7:0] byte_q [$];
    typedef enum int {CS_GOOD, CS_ZERO, CS_BAD} csum_kind_e;

    class status_tracker;
        logic [15:0] byte_count;
        logic [5:0]  header_bytes;
        logic [7:0]  proto;
        logic [15:0] seg_len;
        logic [16:0] sum;
        logic [7:0]  len_hi;
        bit          chk_nz;
        logic [1:0]  status_due [$];
        int          faults;

        function new();
            clear();
            faults = 0;
        endfunction

        function void clear();
            byte_count   = '0;
            header_bytes = '0;
            proto        = '0;
            seg_len      = '0;
            sum          = '0;
            len_hi       = '0;
            chk_nz       = 1'b0;
        endfunction

        function logic [16:0] ones_add(logic [16:0] s, int unsigned v);
            int unsigned t;
            t = s + v;
            t = (t & 32'hFFFF) + (t >> 16);
            t = (t & 32'hFFFF) + (t >> 16);
            return t[16:0];
        endfunction

        function logic [1:0] verdict();
            int unsigned need;
            logic [16:0] s;
            if (byte_count < 10) return ucv_pkg::ST_TRUNCATED;
            if (proto != ucv_pkg::PROTO_UDP) return ucv_pkg::ST_NOT_UDP;
            if (int'(byte_count) < int'(header_bytes) + 6) return ucv_pkg::ST_TRUNCATED;
            if (seg_len < 8) return ucv_pkg::ST_BAD;
            need = int'(header_bytes) + int'(seg_len);
            if (need < 20) need = 20;
            if (int'(byte_count) < need) return ucv_pkg::ST_TRUNCATED;
            if (!chk_nz) return ucv_pkg::ST_GOOD;
            s = ones_add(sum, ucv_pkg::PROTO_UDP);
            return (s == 17'h0FFFF) ? ucv_pkg::ST_GOOD : ucv_pkg::ST_BAD;
        endfunction

        function void take_byte(logic [7:0] b, logic l);
            int unsigned p;
            int unsigned h;
            int unsigned v;
            if (byte_count < ucv_pkg::COUNT_MAX) begin
                p = byte_count;
                v = p[0] ? {24'd0, b} : {16'd0, b, 8'd0};
                if (p == 0) header_bytes = {b[3:0], 2'b00};
                if (p == 9) proto = b;
                h = header_bytes;
                if (p >= 12 && p <= 19) sum = ones_add(sum, v);
                if (p >= h) begin
                    if (p < h + 6 || p < h + seg_len) sum = ones_add(sum, v);
                    if (p == h + 4) len_hi = b;
                    if (p == h + 5) begin
                        seg_len = {len_hi, b};
                        sum = ones_add(sum, seg_len);
                    end
                    if ((p == h + 6 || p == h + 7) && b != 8'd0) chk_nz = 1'b1;
                end
                byte_count = 16'(p + 1);
            end
            if (l) begin
                status_due.push_back(verdict());
                clear();
            end
        endfunction

        function void match_status(logic [1:0] got);
            logic [1:0] want;
            if (status_due.size() == 0) begin
                $display("%0t: status %0d with no packet outstanding, expected none, got %0d",
                         $time, got, got);
                faults++;
            end else begin
                want = status_due.pop_front();
                if (got !== want) begin
                    $display("%0t: status mismatch, expected %0d, got %0d", $time, want, got);
                    faults++;
                end
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n = 1'b0;

    ucv_in_if  in_ch ();
    ucv_out_if out_ch ();

    status_tracker tracker = new();

    int  bytes_sent   = 0;
    int  packets_sent = 0;
    int  cycle_count  = 0;
    bit  tx_steady    = 1'b0;
    bit  rx_steady    = 1'b0;
    bit  held         = 1'b0;

    udp_checksum_verify_core DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    function automatic int tx_gap();
        if ($urandom_range(0, 7) == 0) tx_steady = !tx_steady;
        return tx_steady ? 0 : $urandom_range(0, 7);
    endfunction

    function automatic int rx_gap();
        if ($urandom_range(0, 7) == 0) rx_steady = !rx_steady;
        return rx_steady ? 0 : $urandom_range(0, 7);
    endfunction

    function automatic void make_packet(ref byte_q q, input int ihl, input int field_len,
                                        input int body_len, input logic [7:0] proto,
                                        input csum_kind_e kind, input int trailer);
        int          h;
        int          size;
        logic [31:0] acc;
        logic [15:0] chk;
        logic [7:0]  lo;
        h = ihl * 4;
        size = h + body_len + trailer;
        if (size < 20) size = 20;
        q.delete();
        for (int i = 0; i < size; i++) q.push_back(8'($urandom_range(0, 255)));
        q[0] = {4'h4, ihl[3:0]};
        q[9] = proto;
        q[h + 4] = field_len[15:8];
        q[h + 5] = field_len[7:0];
        q[h + 6] = 8'h00;
        q[h + 7] = 8'h00;
        acc = 32'd0;
        for (int i = 12; i < 20; i += 2) acc += {q[i], q[i + 1]};
        acc += ucv_pkg::PROTO_UDP;
        acc += field_len[15:0];
        for (int i = 0; i < body_len; i += 2) begin
            lo = (i + 1 < body_len) ? q[h + i + 1] : 8'h00;
            acc += {q[h + i], lo};
        end
        while (acc >> 16) acc = (acc & 32'hFFFF) + (acc >> 16);
        chk = ~acc[15:0];
        case (kind)
            CS_GOOD: begin
                q[h + 6] = chk[15:8];
                q[h + 7] = chk[7:0];
            end
            CS_BAD: begin
                chk = chk ^ 16'($urandom_range(1, 16'hFFFF));
                q[h + 6] = chk[15:8];
                q[h + 7] = chk[7:0];
            end
            default: begin
            end
        endcase
    endfunction

    function automatic void make_noise(ref byte_q q, input int len, input int fill);
        q.delete();
        for (int i = 0; i < len; i++) begin
            case (fill)
                0:       q.push_back(8'h00);
                1:       q.push_back(8'hFF);
                default: q.push_back(8'($urandom_range(0, 255)));
            endcase
        end
    endfunction

    task automatic send_byte(input logic [7:0] b, input logic l, input int gap);
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.data_byte <= b;
        in_ch.last_byte <= l;
        do @(posedge i_clk); while (!in_ch.ready);
        tracker.take_byte(b, l);
        bytes_sent++;
    endtask

    task automatic send_packet(ref byte_q q);
        foreach (q[i]) send_byte(q[i], i == q.size() - 1, tx_gap());
        packets_sent++;
    endtask

    task automatic send_shaped(input int ihl, input int field_len, input int body_len,
                               input logic [7:0] proto, input csum_kind_e kind,
                               input int trailer, input int cut);
        byte_q q;
        make_packet(q, ihl, field_len, body_len, proto, kind, trailer);
        if (cut > 0)
            while (q.size() > cut) void'(q.pop_back());
        send_packet(q);
    endtask

    task automatic run_directed();
        byte_q q;
        make_noise(q, 1, 1);
        send_packet(q);
        send_shaped(5, 12, 12, ucv_pkg::PROTO_UDP, CS_GOOD, 0, 9);
        send_shaped(5, 12, 12, 8'h06, CS_GOOD, 0, 0);
        send_shaped(5, 12, 12, ucv_pkg::PROTO_UDP, CS_GOOD, 0, 10);
        send_shaped(5, 4, 8, ucv_pkg::PROTO_UDP, CS_GOOD, 0, 0);
        send_shaped(5, 16, 16, ucv_pkg::PROTO_UDP, CS_GOOD, 5, 0);
        send_shaped(5, 10, 10, ucv_pkg::PROTO_UDP, CS_ZERO, 0, 0);
        send_shaped(5, 14, 14, ucv_pkg::PROTO_UDP, CS_BAD, 0, 0);
        send_shaped(5, 13, 13, ucv_pkg::PROTO_UDP, CS_GOOD, 0, 0);
        send_shaped(5, 20, 20, ucv_pkg::PROTO_UDP, CS_GOOD, 0, 39);
        send_shaped(0, 8, 8, ucv_pkg::PROTO_UDP, CS_GOOD, 0, 0);
        send_shaped(3, 10, 10, ucv_pkg::PROTO_UDP, CS_GOOD, 2, 0);
        send_shaped(15, 9, 9, ucv_pkg::PROTO_UDP, CS_GOOD, 0, 0);
        make_noise(q, 20, 0);
        send_packet(q);
        make_noise(q, 24, 1);
        send_packet(q);
    endtask

    task automatic run_random();
        byte_q      q;
        int         pick;
        int         ihl;
        int         body;
        int         field;
        int         trailer;
        int         cut;
        logic [7:0] proto;
        csum_kind_e kind;
        while (bytes_sent < RANDOM_BYTES || packets_sent < MIN_PACKETS) begin
            pick    = $urandom_range(0, 99);
            ihl     = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 15) : 5;
            body    = 8 + $urandom_range(0, 24);
            field   = body;
            proto   = ucv_pkg::PROTO_UDP;
            trailer = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 4) : 0;
            cut     = 0;
            case ($urandom_range(0, 19))
                0, 1, 2:    kind = CS_ZERO;
                3, 4, 5, 6: kind = CS_BAD;
                default:    kind = CS_GOOD;
            endcase
            if (pick >= 85) begin
                make_noise(q, $urandom_range(1, 40), $urandom_range(0, 9));
                send_packet(q);
            end else begin
                if (pick >= 70) begin
                    case ($urandom_range(0, 3))
                        0:       cut = $urandom_range(1, ihl * 4 + body + trailer - 1);
                        1:       proto = 8'($urandom_range(0, 255));
                        2:       field = $urandom_range(0, 40);
                        default: ihl = $urandom_range(0, 4);
                    endcase
                end
                send_shaped(ihl, field, body, proto, kind, trailer, cut);
            end
        end
    endtask

    initial begin
        int gap;
        int seen;
        seen = 0;
        out_ch.ready <= 1'b0;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (!held && seen == HOLD_AT) begin
                held = 1'b1;
                gap = HOLD_CYCLES;
            end else begin
                gap = rx_gap();
            end
            if (gap > 0) begin
                out_ch.ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            out_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!out_ch.valid);
            tracker.match_status(out_ch.status);
            seen++;
        end
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("[udp_checksum_verify_core] ERROR");
        $finish;
    end

    initial begin
        int drain;
        drain = 0;
        in_ch.valid     <= 1'b0;
        in_ch.data_byte <= 8'h00;
        in_ch.last_byte <= 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        run_directed();
        run_random();
        in_ch.valid <= 1'b0;
        while (tracker.status_due.size() > 0 && drain < DRAIN_LIMIT) begin
            @(posedge i_clk);
            drain++;
        end
        repeat (SETTLE) @(posedge i_clk);
        if (tracker.status_due.size() > 0) begin
            $display("%0t: packets without status, expected 0, got %0d outstanding",
                     $time, tracker.status_due.size());
            tracker.faults++;
        end
        if (tracker.faults == 0) begin
            $display("[udp_checksum_verify_core] OK");
        end else begin
            $display("[udp_checksum_verify_core] ERROR");
        end
        $finish;
    end

endmodule

>>> files.f
rtl/ucv_pkg.sv
rtl/ucv_if.sv
rtl/ucv_state.sv
rtl/ucv_decide.sv
rtl/udp_checksum_verify_core.sv
sim/tb.sv
